// ----- rtl/core/lru_block_cache_tags_core_assert.svh -----
// Assertion macros for the block cache tag engine.
// Expects clk and rst to be visible in the module that uses them.
`ifndef LRU_BLOCK_CACHE_TAGS_CORE_ASSERT_SVH
`define LRU_BLOCK_CACHE_TAGS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBCT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lbct assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBCT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lbct assertion failed");

`endif

// ----- rtl/core/lbct_pkg.sv -----
// Package of the block cache tag engine: sizes, request codes and transfer types.
// Used by lbct_front, lbct_back and lru_block_cache_tags_core; depends on nothing.
`default_nettype none

package lbct_pkg;

  localparam int WAYS    = 16;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int GROUP   = 8;
  localparam int NGROUPS = (WAYS + GROUP - 1) / GROUP;

  localparam int FID_W   = 32;
  localparam int BLK_W   = 23;
  localparam int TW_W    = 4;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [1:0] REQ_LOOKUP      = 2'd0;
  localparam logic [1:0] REQ_FILL_DONE   = 2'd1;
  localparam logic [1:0] REQ_FILL_FAILED = 2'd2;
  localparam logic [1:0] REQ_CLOSE       = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [FID_W-1:0] file_ident;
    logic [BLK_W-1:0] block_num;
    logic [TW_W-1:0]  target_way;
  } lbct_req_t;

  typedef struct packed {
    logic             hit;
    logic [TW_W-1:0]  way;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } lbct_rsp_t;

  typedef struct packed {
    logic lookup;
    logic fill;
    logic drop;
    logic close;
  } lbct_kind_t;

  typedef struct packed {
    lbct_kind_t       kind;
    logic             tw_ok;
    logic [WAY_W-1:0] tw_idx;
    lbct_req_t        req;
  } lbct_op_t;

endpackage

`default_nettype wire

// ----- rtl/core/lbct_front.sv -----
// Front end: takes requests, decodes them and holds them in a short queue.
// Depends on lbct_pkg and the assertion macro header.
`default_nettype none
`include "lru_block_cache_tags_core_assert.svh"

module lbct_front import lbct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  lbct_req_t req,
  output logic      q_valid,
  output lbct_op_t  q_item,
  input  logic      q_pop
);

  lbct_op_t            queue [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic                push;
  lbct_op_t            op;

  always_comb begin
    op        = '0;
    op.req    = req;
    op.tw_idx = WAY_W'(req.target_way);
    op.tw_ok  = (int'(req.target_way) < WAYS);
    unique case (req.req_type)
      REQ_LOOKUP:      op.kind.lookup = 1'b1;
      REQ_FILL_DONE:   op.kind.fill   = 1'b1;
      REQ_FILL_FAILED: op.kind.drop   = 1'b1;
      REQ_CLOSE:       op.kind.close  = 1'b1;
      default:         op.kind        = '0;
    endcase
  end

  assign busy    = (count == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_item  = queue[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + QCNT_W'(1);
    end else if (!push && q_pop) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= op;
    end
  end

  `LBCT_ASSERT_NOW(a_count_max, 1'b1, count <= QCNT_W'(QDEPTH))
  `LBCT_ASSERT_NOW(a_pop_nonempty, q_pop, count != '0)
  `LBCT_ASSERT_NEXT(a_push_grows, push && !q_pop, count == $past(count) + QCNT_W'(1))

endmodule

`default_nettype wire

// ----- rtl/core/lbct_back.sv -----
// Back end: tag compare, stamp-age reduction and state update for one request at a time.
// Depends on lbct_pkg and the assertion macro header.
`default_nettype none
`include "lru_block_cache_tags_core_assert.svh"

module lbct_back import lbct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  lbct_op_t  q_item,
  output logic      q_pop,
  output logic      done,
  output lbct_rsp_t rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_RED  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  lbct_op_t           cur;

  logic [FID_W-1:0]   tag_file    [WAYS];
  logic [BLK_W-1:0]   tag_block   [WAYS];
  logic [STAMP_W-1:0] entry_stamp [WAYS];
  logic [WAYS-1:0]    entry_valid;
  logic [STAMP_W-1:0] now_stamp;
  logic [CNT_W-1:0]   hit_cnt;
  logic [CNT_W-1:0]   miss_cnt;

  logic [WAYS-1:0]    match_c;
  logic [WAYS-1:0]    fmatch_c;
  logic [WAY_W-1:0]   hit_idx_c;
  logic [WAY_W-1:0]   inv_idx_c;
  logic [WAYS-1:0]    fmatch_r;
  logic               any_match_r;
  logic               any_inv_r;
  logic [WAY_W-1:0]   hit_idx_r;
  logic [WAY_W-1:0]   inv_idx_r;
  logic [STAMP_W-1:0] age_r [WAYS];

  logic [WAY_W-1:0]   grp_idx_c [NGROUPS];
  logic [STAMP_W-1:0] grp_age_c [NGROUPS];
  logic [WAY_W-1:0]   grp_idx_r [NGROUPS];
  logic [STAMP_W-1:0] grp_age_r [NGROUPS];

  logic [WAY_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_age;
  logic [WAY_W-1:0]   way_sel;
  logic [STAMP_W-1:0] stamp_inc;
  logic [CNT_W-1:0]   hit_cnt_next;
  logic [CNT_W-1:0]   miss_cnt_next;

  assign q_pop = q_valid && ((state == ST_IDLE) || (state == ST_FIN));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: state_next = q_valid ? ST_CMP : ST_IDLE;
      ST_CMP:  state_next = ST_RED;
      ST_RED:  state_next = ST_FIN;
      ST_FIN:  state_next = q_valid ? ST_CMP : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
  end

  always_comb begin
    hit_idx_c = '0;
    inv_idx_c = '0;
    for (int i = 0; i < WAYS; i++) begin
      fmatch_c[i] = entry_valid[i] && (tag_file[i] == cur.req.file_ident);
      match_c[i]  = fmatch_c[i] && (tag_block[i] == cur.req.block_num);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match_c[i]) begin
        hit_idx_c = WAY_W'(i);
      end
      if (!entry_valid[i]) begin
        inv_idx_c = WAY_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      fmatch_r    <= fmatch_c;
      any_match_r <= |match_c;
      any_inv_r   <= ~&entry_valid;
      hit_idx_r   <= hit_idx_c;
      inv_idx_r   <= inv_idx_c;
      for (int i = 0; i < WAYS; i++) begin
        age_r[i] <= now_stamp - entry_stamp[i];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      grp_idx_c[g] = WAY_W'(g * GROUP);
      grp_age_c[g] = age_r[g * GROUP];
      for (int k = 1; k < GROUP; k++) begin
        if ((g * GROUP + k) < WAYS) begin
          if (age_r[g * GROUP + k] >= grp_age_c[g]) begin
            grp_age_c[g] = age_r[g * GROUP + k];
            grp_idx_c[g] = WAY_W'(g * GROUP + k);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RED) begin
      for (int g = 0; g < NGROUPS; g++) begin
        grp_idx_r[g] <= grp_idx_c[g];
        grp_age_r[g] <= grp_age_c[g];
      end
    end
  end

  always_comb begin
    best_idx = grp_idx_r[0];
    best_age = grp_age_r[0];
    for (int g = 1; g < NGROUPS; g++) begin
      if (grp_age_r[g] >= best_age) begin
        best_age = grp_age_r[g];
        best_idx = grp_idx_r[g];
      end
    end
  end

  always_comb begin
    stamp_inc     = now_stamp + STAMP_W'(1);
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    if (any_match_r) begin
      way_sel = hit_idx_r;
    end else if (any_inv_r) begin
      way_sel = inv_idx_r;
    end else begin
      way_sel = best_idx;
    end
    if (cur.kind.lookup) begin
      if (any_match_r) begin
        hit_cnt_next = hit_cnt + CNT_W'(1);
      end else begin
        miss_cnt_next = miss_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      now_stamp   <= '0;
      hit_cnt     <= '0;
      miss_cnt    <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == ST_FIN);
      if (state == ST_FIN) begin
        hit_cnt  <= hit_cnt_next;
        miss_cnt <= miss_cnt_next;
        if (cur.kind.lookup && any_match_r) begin
          now_stamp <= stamp_inc;
        end
        if (cur.kind.fill && cur.tw_ok) begin
          now_stamp               <= stamp_inc;
          entry_valid[cur.tw_idx] <= 1'b1;
        end
        if (cur.kind.drop && cur.tw_ok) begin
          entry_valid[cur.tw_idx] <= 1'b0;
        end
        if (cur.kind.close) begin
          entry_valid <= entry_valid & ~fmatch_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      if (cur.kind.lookup && any_match_r) begin
        entry_stamp[hit_idx_r] <= stamp_inc;
      end
      if (cur.kind.fill && cur.tw_ok) begin
        tag_file[cur.tw_idx]    <= cur.req.file_ident;
        tag_block[cur.tw_idx]   <= cur.req.block_num;
        entry_stamp[cur.tw_idx] <= stamp_inc;
      end
      rsp.hit        <= cur.kind.lookup && any_match_r;
      rsp.way        <= cur.kind.lookup ? TW_W'(way_sel) : cur.req.target_way;
      rsp.hit_total  <= hit_cnt_next;
      rsp.miss_total <= miss_cnt_next;
    end
  end

  `LBCT_ASSERT_NEXT(a_fin_done, state == ST_FIN, done)
  `LBCT_ASSERT_NEXT(a_done_only_fin, state != ST_FIN, !done)
  `LBCT_ASSERT_NOW(a_hit_lookup, done && rsp.hit, $past(cur.kind.lookup))
  `LBCT_ASSERT_NEXT(a_hit_count, (state == ST_FIN) && cur.kind.lookup && any_match_r,
                    hit_cnt == $past(hit_cnt) + CNT_W'(1))

endmodule

`default_nettype wire

// ----- rtl/core/lru_block_cache_tags_core.sv -----
// Top level of the block cache tag engine: front queue plus back execution engine.
// Depends on lbct_pkg, lbct_front and lbct_back.
`default_nettype none

// A request is taken at a clock edge where start is high and busy is low; busy rises only
// while the two-entry request queue is full. Each request gives exactly one result, shown
// on rsp for a single cycle with done high, in request order; the receiver cannot stall
// it and must capture it in that cycle. A taken request waits in the queue, is loaded
// into the engine and then passes the parallel tag compare and stamp ages, the group age
// reduction and the final victim choice with the state update; done is registered from
// that last step. Back to back, the next queued request is loaded as the last one ends.
module lru_block_cache_tags_core import lbct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  lbct_req_t req,
  output logic      done,
  output lbct_rsp_t rsp
);

  logic     q_valid;
  logic     q_pop;
  lbct_op_t q_item;

  lbct_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  lbct_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .done    (done),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
